// File: rtl/dq_pkg.sv
// shared types, codes and sizes for the bounded deque with search
// used by dq_ctl, dq_dp and the top level; no dependencies
package dq_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int FUNC_W  = 3;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	typedef logic        [FUNC_W-1:0]  func_t;
	typedef logic signed [DATA_W-1:0]  data_t;
	typedef logic        [STAT_W-1:0]  status_t;
	typedef logic        [COUNT_W-1:0] count_t;

	// operation codes
	localparam func_t FN_PUSH_FRONT = 3'd0;
	localparam func_t FN_PUSH_BACK  = 3'd1;
	localparam func_t FN_POP_FRONT  = 3'd2;
	localparam func_t FN_POP_BACK   = 3'd3;
	localparam func_t FN_REMOVE     = 3'd4;
	localparam func_t FN_CONTAINS   = 3'd5;

	// status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_FULL      = 2'd1;
	localparam status_t ST_EMPTY     = 2'd2;
	localparam status_t ST_NOT_FOUND = 2'd3;

	// read address selects
	localparam logic [1:0] RD_IDX   = 2'd0;
	localparam logic [1:0] RD_NEXT  = 2'd1;
	localparam logic [1:0] RD_FRONT = 2'd2;
	localparam logic [1:0] RD_BACK  = 2'd3;

	// write address selects
	localparam logic [1:0] WR_HEAD_M1 = 2'd0;
	localparam logic [1:0] WR_TAIL    = 2'd1;
	localparam logic [1:0] WR_IDX     = 2'd2;

	typedef struct packed {
		logic          load;
		logic          head_dec;
		logic          head_inc;
		logic          cnt_inc;
		logic          cnt_dec;
		logic          wr_en;
		logic [1:0]    wr_sel;
		logic          rd_en;
		logic [1:0]    rd_sel;
		logic          idx_clr;
		logic          idx_inc;
		logic          st_ld;
		status_t       st;
		logic          found_set;
		logic          front_ld;
		logic          res_ld;
	} dq_cmd_t;

	typedef struct packed {
		func_t func;
		logic  full;
		logic  empty;
		logic  idx_end;
		logic  idx_last;
		logic  match;
	} dq_sts_t;

endpackage

// File: rtl/bounded_deque_with_search.sv
// top level of the bounded deque with search: controller plus datapath
// depends on dq_pkg, dq_ctl, dq_dp (and dq_ram through dq_dp)
//
//   channel  | handshake          | word
//   ---------+--------------------+----------------------------------------------
//   command  | start, busy        | func, value
//   result   | done (one cycle)   | status, front_value, back_value, count,
//            |                    | empty_res, found
//
// a command word is taken when start is high and busy is low; its result word shows for
// the one cycle done marks and cannot be held off; reset empties the deque, not the store
// push, pop and unused codes go from accept through execute, the front and back reads
// through the one ram read port, and the result load
// a search reads and compares each element in turn from the front; a remove hit then
// moves each later word one slot toward the front and drops the last slot
module bounded_deque_with_search (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  dq_pkg::func_t   func,
	input  dq_pkg::data_t   value,
	output logic            done,
	output dq_pkg::status_t status,
	output dq_pkg::data_t   front_value,
	output dq_pkg::data_t   back_value,
	output dq_pkg::count_t  count,
	output logic            empty_res,
	output logic            found
);
	import dq_pkg::*;

	dq_cmd_t cmd;
	dq_sts_t sts;

	dq_ctl u_ctl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	dq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (func),
		.value      (value),
		.done       (done),
		.status     (status),
		.front_value(front_value),
		.back_value (back_value),
		.count      (count),
		.empty_res  (empty_res),
		.found      (found)
	);

endmodule

// File: rtl/dq_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/dq_dp.sv
// datapath of the deque: head and count registers, search index, element ram,
// result registers; depends on dq_pkg and dq_ram
module dq_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  dq_pkg::dq_cmd_t  cmd,
	output dq_pkg::dq_sts_t  sts,
	input  dq_pkg::func_t    func,
	input  dq_pkg::data_t    value,
	output logic             done,
	output dq_pkg::status_t  status,
	output dq_pkg::data_t    front_value,
	output dq_pkg::data_t    back_value,
	output dq_pkg::count_t   count,
	output logic             empty_res,
	output logic             found
);
	import dq_pkg::*;

	localparam logic [IDX_W:0] DEPTH_S = (IDX_W + 1)'(DEPTH);
	localparam logic [IDX_W-1:0] LAST_S = IDX_W'(DEPTH - 1);

	func_t            func_q;
	data_t            value_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	status_t          status_q;
	logic             found_q;
	data_t            front_q;

	logic [IDX_W-1:0] head_m1;
	logic [CNT_W-1:0] idx_p1;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W:0]   idx_next_w;
	logic [IDX_W-1:0] raddr;
	logic [IDX_W-1:0] waddr;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] rdata;
	data_t            rdata_s;

	// position of an element counted from the front, wrapped into the store
	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, head} + {1'b0, off};
		if (s >= DEPTH_S) begin
			s = s - DEPTH_S;
		end
		return s[IDX_W-1:0];
	endfunction

	assign head_m1    = (head_q == '0) ? LAST_S : head_q - 1'b1;
	assign idx_p1     = idx_q + 1'b1;
	assign cnt_m1     = cnt_q - 1'b1;
	assign idx_next_w = {1'b0, idx_q} + (CNT_W + 1)'(1);
	assign rdata_s    = data_t'(rdata);

	assign sts.func     = func_q;
	assign sts.full     = (cnt_q == CNT_W'(DEPTH));
	assign sts.empty    = (cnt_q == '0);
	assign sts.idx_end  = (idx_q == cnt_q);
	assign sts.idx_last = (idx_next_w >= {1'b0, cnt_q});
	assign sts.match    = (rdata_s == value_q);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_IDX:   raddr = slot(head_q, idx_q[IDX_W-1:0]);
			RD_NEXT:  raddr = slot(head_q, idx_p1[IDX_W-1:0]);
			RD_FRONT: raddr = head_q;
			RD_BACK:  raddr = slot(head_q, cnt_m1[IDX_W-1:0]);
			default:  raddr = head_q;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WR_HEAD_M1: waddr = head_m1;
			WR_TAIL:    waddr = slot(head_q, cnt_q[IDX_W-1:0]);
			WR_IDX:     waddr = slot(head_q, idx_q[IDX_W-1:0]);
			default:    waddr = head_q;
		endcase
	end

	// shifting moves a stored word, pushes store the input word
	assign wdata = (cmd.wr_sel == WR_IDX) ? rdata : DATA_W'(value_q);

	dq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= cmd.res_ld;
			if (cmd.head_dec) begin
				head_q <= head_m1;
			end else if (cmd.head_inc) begin
				head_q <= slot(head_q, IDX_W'(1));
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			value_q  <= value;
			status_q <= ST_OK;
			found_q  <= 1'b0;
		end else begin
			if (cmd.st_ld) begin
				status_q <= cmd.st;
			end
			if (cmd.found_set) begin
				found_q <= 1'b1;
			end
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_p1;
		end
		if (cmd.front_ld) begin
			front_q <= (cnt_q == '0) ? '0 : rdata_s;
		end
		if (cmd.res_ld) begin
			status      <= status_q;
			found       <= found_q;
			front_value <= front_q;
			back_value  <= (cnt_q == '0) ? '0 : rdata_s;
			count       <= COUNT_W'(cnt_q);
			empty_res   <= (cnt_q == '0);
		end
	end

endmodule

// File: rtl/dq_ctl.sv
// controller state machine of the deque: sequences pushes, pops, search,
// gap closing and the front/back read-out; depends on dq_pkg
module dq_ctl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  dq_pkg::dq_sts_t  sts,
	output dq_pkg::dq_cmd_t  cmd
);
	import dq_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_EXEC     = 4'd1;
	localparam logic [3:0] S_SRCH_RD  = 4'd2;
	localparam logic [3:0] S_SRCH_CMP = 4'd3;
	localparam logic [3:0] S_SHIFT_RD = 4'd4;
	localparam logic [3:0] S_SHIFT_WR = 4'd5;
	localparam logic [3:0] S_FRONT_RD = 4'd6;
	localparam logic [3:0] S_BACK_RD  = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FRONT_RD;
				unique case (sts.func)
					FN_PUSH_FRONT: begin
						if (sts.full) begin
							cmd.st_ld = 1'b1;
							cmd.st    = ST_FULL;
						end else begin
							cmd.wr_en    = 1'b1;
							cmd.wr_sel   = WR_HEAD_M1;
							cmd.head_dec = 1'b1;
							cmd.cnt_inc  = 1'b1;
						end
					end
					FN_PUSH_BACK: begin
						if (sts.full) begin
							cmd.st_ld = 1'b1;
							cmd.st    = ST_FULL;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_sel  = WR_TAIL;
							cmd.cnt_inc = 1'b1;
						end
					end
					FN_POP_FRONT: begin
						if (sts.empty) begin
							cmd.st_ld = 1'b1;
							cmd.st    = ST_EMPTY;
						end else begin
							cmd.head_inc = 1'b1;
							cmd.cnt_dec  = 1'b1;
						end
					end
					FN_POP_BACK: begin
						if (sts.empty) begin
							cmd.st_ld = 1'b1;
							cmd.st    = ST_EMPTY;
						end else begin
							cmd.cnt_dec = 1'b1;
						end
					end
					FN_REMOVE, FN_CONTAINS: begin
						cmd.idx_clr = 1'b1;
						state_d     = S_SRCH_RD;
					end
					default: begin
						state_d = S_FRONT_RD;
					end
				endcase
			end
			S_SRCH_RD: begin
				if (sts.idx_end) begin
					if (sts.func == FN_REMOVE) begin
						cmd.st_ld = 1'b1;
						cmd.st    = ST_NOT_FOUND;
					end
					state_d = S_FRONT_RD;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX;
					state_d    = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (sts.match) begin
					cmd.found_set = 1'b1;
					state_d = (sts.func == FN_CONTAINS) ? S_FRONT_RD : S_SHIFT_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SRCH_RD;
				end
			end
			S_SHIFT_RD: begin
				// close the gap one word at a time, then drop the last slot
				if (sts.idx_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FRONT_RD;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
					state_d    = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_IDX;
				cmd.idx_inc = 1'b1;
				state_d     = S_SHIFT_RD;
			end
			S_FRONT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_FRONT;
				state_d    = S_BACK_RD;
			end
			S_BACK_RD: begin
				cmd.front_ld = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = RD_BACK;
				state_d      = S_DONE;
			end
			S_DONE: begin
				cmd.res_ld = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
